@@ design/psc_pkg.sv @@
// Package: shared types, signature tables and constants for the classifier.
`timescale 1ns / 1ps
`default_nettype none
package psc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_payload;
  } in_item_t;

  typedef struct packed {
    logic login_match;
    logic control_match;
  } out_item_t;

  // Step control handed to both trackers.
  typedef struct packed {
    logic step;
    logic last;
  } trk_ctl_t;

  localparam int unsigned PfxCount = 4;
  localparam logic [2:0] PfxWindow = 3'd4;
  localparam logic [2:0] TailLen = 3'd5;
  localparam logic [4:0] SigLen = 5'd26;
  localparam logic [7:0] QuoteCode = 8'h22;
  localparam logic [7:0] NulCode = 8'h00;
  localparam logic [3:0] PfxAllAlive = 4'hF;

  function automatic logic [2:0] pfx_len(input logic [1:0] alt);
    logic [2:0] len;
    case (alt)
      2'd0: len = 3'd4;
      default: len = 3'd3;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] pfx_byte(input logic [1:0] alt, input logic [1:0] pos);
    logic [7:0] val;
    case ({alt, pos})
      4'b00_00: val = 8'h56;
      4'b00_01: val = 8'h45;
      4'b00_10: val = 8'h52;
      4'b00_11: val = 8'h20;
      4'b01_00: val = 8'h43;
      4'b01_01: val = 8'h56;
      4'b01_10: val = 8'h52;
      4'b10_00: val = 8'h55;
      4'b10_01: val = 8'h53;
      4'b10_10: val = 8'h52;
      4'b11_00: val = 8'h41;
      4'b11_01: val = 8'h4E;
      4'b11_10: val = 8'h53;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  function automatic logic [7:0] tail_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0: val = 8'h20;
      3'd1: val = 8'h4D;
      3'd2: val = 8'h53;
      3'd3: val = 8'h4E;
      3'd4: val = 8'h50;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  function automatic logic [7:0] sig_byte(input logic [4:0] idx);
    logic [7:0] val;
    case (idx)
      5'd0: val = 8'h22;
      5'd1: val = 8'h76;
      5'd2: val = 8'h6F;
      5'd3: val = 8'h69;
      5'd4: val = 8'h63;
      5'd5: val = 8'h65;
      5'd6: val = 8'h2E;
      5'd7: val = 8'h6D;
      5'd8: val = 8'h65;
      5'd9: val = 8'h73;
      5'd10: val = 8'h73;
      5'd11: val = 8'h65;
      5'd12: val = 8'h6E;
      5'd13: val = 8'h67;
      5'd14: val = 8'h65;
      5'd15: val = 8'h72;
      5'd16: val = 8'h2E;
      5'd17: val = 8'h6C;
      5'd18: val = 8'h69;
      5'd19: val = 8'h76;
      5'd20: val = 8'h65;
      5'd21: val = 8'h2E;
      5'd22: val = 8'h63;
      5'd23: val = 8'h6F;
      5'd24: val = 8'h6D;
      5'd25: val = 8'h22;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

@@ design/psc_login.sv @@
// Login command tracker: prefix alternatives, NUL cut-off and tail substring search.
`timescale 1ns / 1ps
`default_nettype none
module psc_login
  import psc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire trk_ctl_t   ctl,
  input  wire logic [7:0] data_byte,
  output logic            login_next
);

  logic [2:0] byte_position, byte_position_next;
  logic [3:0] prefix_alive, prefix_alive_next;
  logic       nul_seen, nul_seen_next;
  logic [2:0] suffix_progress, suffix_progress_next;
  logic       login_found;

  always_comb begin
    byte_position_next   = byte_position;
    prefix_alive_next    = prefix_alive;
    nul_seen_next        = nul_seen;
    suffix_progress_next = suffix_progress;
    login_next           = login_found;
    if (nul_seen) begin
      login_next = login_found;
    end else if (data_byte == NulCode) begin
      nul_seen_next = 1'b1;
    end else if (byte_position < PfxWindow) begin
      for (int i = 0; i < PfxCount; i++) begin
        if (prefix_alive[i] && (byte_position < pfx_len(2'(i)))) begin
          if (data_byte != pfx_byte(2'(i), byte_position[1:0])) begin
            prefix_alive_next[i] = 1'b0;
          end else if ((i != 0) && (byte_position == (pfx_len(2'(i)) - 3'd1))) begin
            login_next = 1'b1;
          end
        end
      end
      byte_position_next = byte_position + 3'd1;
    end else if (prefix_alive[0] && (suffix_progress < TailLen)) begin
      if (data_byte == tail_byte(suffix_progress)) begin
        suffix_progress_next = suffix_progress + 3'd1;
      end else begin
        suffix_progress_next = (data_byte == tail_byte(3'd0)) ? 3'd1 : 3'd0;
      end
      if (suffix_progress_next >= TailLen) begin
        login_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (ctl.step && ctl.last)) begin
      byte_position   <= '0;
      prefix_alive    <= PfxAllAlive;
      nul_seen        <= 1'b0;
      suffix_progress <= '0;
      login_found     <= 1'b0;
    end else if (ctl.step) begin
      byte_position   <= byte_position_next;
      prefix_alive    <= prefix_alive_next;
      nul_seen        <= nul_seen_next;
      suffix_progress <= suffix_progress_next;
      login_found     <= login_next;
    end
  end

endmodule
`default_nettype wire

@@ design/psc_control.sv @@
// Control signature tracker: finds the first quote and compares the following window.
`timescale 1ns / 1ps
`default_nettype none
module psc_control
  import psc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire trk_ctl_t   ctl,
  input  wire logic [7:0] data_byte,
  output logic            control_next
);

  logic       quote_found, quote_found_next;
  logic [4:0] compare_index, compare_index_next;
  logic       compare_failed, compare_failed_next;
  logic       control_found;

  always_comb begin
    quote_found_next    = quote_found;
    compare_index_next  = compare_index;
    compare_failed_next = compare_failed;
    control_next        = control_found;
    if (!quote_found) begin
      if (data_byte == QuoteCode) begin
        quote_found_next   = 1'b1;
        compare_index_next = 5'd1;
      end
    end else if (compare_index < SigLen) begin
      if (data_byte != sig_byte(compare_index)) begin
        compare_failed_next = 1'b1;
      end
      compare_index_next = compare_index + 5'd1;
      if ((compare_index_next == SigLen) && !compare_failed_next) begin
        control_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (ctl.step && ctl.last)) begin
      quote_found    <= 1'b0;
      compare_index  <= '0;
      compare_failed <= 1'b0;
      control_found  <= 1'b0;
    end else if (ctl.step) begin
      quote_found    <= quote_found_next;
      compare_index  <= compare_index_next;
      compare_failed <= compare_failed_next;
      control_found  <= control_next;
    end
  end

endmodule
`default_nettype wire

@@ design/payload_signature_classifier.sv @@
// Usage notes:
// Payload bytes enter on the in channel (in_valid/in_ready, in_item), one request
// per byte, with end_of_payload set on the final byte of each payload.
// One result request (login_match, control_match) leaves on the out channel
// (out_valid/out_ready, out_item) for each payload, after its final byte.
// Bytes that are not final produce no result request.
// A final byte accepted into the input register is evaluated there by the
// trackers, and its result is then captured in the result register.
// Throughput: one byte per cycle, set by the single input register feeding
// the tracker logic and the single result register, unless a final byte waits.
// When the receiver stalls, the pending result holds in the result register;
// non-final bytes keep flowing, and a second final byte waits in the input
// register, with in_ready low, until the result slot is free.
// Reset (rst, synchronous) empties both registers and returns all tracking
// state to its idle values; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module payload_signature_classifier
  import psc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  logic     s1_valid;
  in_item_t s1_item;
  logic     s1_go;
  trk_ctl_t ctl;
  logic     login_next;
  logic     control_next;

  // A final byte may only be evaluated when the result slot is free or draining.
  assign s1_go    = s1_valid && (!s1_item.end_of_payload || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  assign ctl.step = s1_go;
  assign ctl.last = s1_item.end_of_payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item <= in_item;
    end
  end

  psc_login u_login (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .data_byte  (s1_item.data_byte),
    .login_next (login_next)
  );

  psc_control u_control (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .data_byte    (s1_item.data_byte),
    .control_next (control_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_item.end_of_payload) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_item.end_of_payload) begin
      out_item.login_match   <= login_next;
      out_item.control_match <= control_next;
    end
  end

`ifndef ASSERT_OFF
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_item)))
    else $error("input register lost or changed a stalled request");

  a_final_makes_result: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_item.end_of_payload) |=> out_valid)
    else $error("final byte evaluated without a result request");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(s1_go && s1_item.end_of_payload))
    else $error("pending result would be overwritten");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

@@ tb/payload_signature_classifier_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for payload_signature_classifier with a built-in predictor.
module payload_signature_classifier_tb;
  import psc_pkg::*;

  localparam int HalfPeriod = 5;
  localparam int ResetCycles = 12;
  localparam int RandomBytes = 310;
  localparam int MinPayloads = 15;
  localparam int HoldPoint = 150;
  localparam int HoldBurst = 12;
  localparam int LongHold = 150;
  localparam int CalmTail = 60;
  localparam int DrainCycles = 8;
  localparam int IdleLimit = 2000;
  localparam int VerAlt = 0;
  localparam int SigBytes = 26;

  // Four login openings, one per 32-bit slot, first byte in the top slot.
  localparam logic [8*16-1:0] LoginPrefixes = {
    8'h56, 8'h45, 8'h52, 8'h20,
    8'h43, 8'h56, 8'h52, 8'h00,
    8'h55, 8'h53, 8'h52, 8'h00,
    8'h41, 8'h4E, 8'h53, 8'h00};
  localparam logic [8*5-1:0] TailText = {8'h20, 8'h4D, 8'h53, 8'h4E, 8'h50};
  localparam logic [8*SigBytes-1:0] HostSig = {
    8'h22, 8'h76, 8'h6F, 8'h69, 8'h63, 8'h65, 8'h2E, 8'h6D, 8'h65, 8'h73, 8'h73, 8'h65, 8'h6E,
    8'h67, 8'h65, 8'h72, 8'h2E, 8'h6C, 8'h69, 8'h76, 8'h65, 8'h2E, 8'h63, 8'h6F, 8'h6D, 8'h22};

  typedef struct {
    in_item_t item;
    bit       pause;
    bit       hold;
  } queued_byte_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  queued_byte_t byte_queue[$];
  out_item_t    expected_results[$];
  logic [7:0]   payload_text[$];

  // Predictor state.
  logic [2:0] pos;
  logic [3:0] alive;
  logic       nul_seen;
  logic [2:0] tail_cnt;
  logic       login_hit;
  logic       quote_seen;
  logic [4:0] sig_idx;
  logic       sig_bad;
  logic       control_hit;

  bit in_took;
  bit cur_hold;
  bit hold_req;
  bit calm;
  int gap_left;
  int stall_left;
  int hold_left;
  int idle_cycles;
  int errors;
  int bytes_taken;
  int payloads_done;
  int login_hits;
  int control_hits;
  int built_bytes;
  int built_payloads;

  payload_signature_classifier u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  always #HalfPeriod clk = ~clk;

  task automatic clear_tracking();
    pos = '0;
    alive = PfxAllAlive;
    nul_seen = 1'b0;
    tail_cnt = '0;
    login_hit = 1'b0;
    quote_seen = 1'b0;
    sig_idx = '0;
    sig_bad = 1'b0;
    control_hit = 1'b0;
  endtask

  // Advances both trackers by one byte; a result exists only on the final byte.
  task automatic classify_byte(input in_item_t it, output bit has_res, output out_item_t res);
    int alt;
    logic [7:0] b;
    b = it.data_byte;
    if (!nul_seen) begin
      if (b == NulCode) begin
        nul_seen = 1'b1;
      end else if (pos < PfxWindow) begin
        for (alt = 0; alt < PfxCount; alt++) begin
          if (alive[alt] && pos < ((alt == VerAlt) ? 3'd4 : 3'd3)) begin
            if (b != LoginPrefixes[8*(15 - (alt*4 + pos)) +: 8]) begin
              alive[alt] = 1'b0;
            end else if (alt != VerAlt && pos == 3'd2) begin
              login_hit = 1'b1;
            end
          end
        end
        pos = pos + 3'd1;
      end else if (alive[VerAlt] && tail_cnt < TailLen) begin
        if (b == TailText[8*(4 - tail_cnt) +: 8]) begin
          tail_cnt = tail_cnt + 3'd1;
        end else begin
          tail_cnt = (b == TailText[39:32]) ? 3'd1 : 3'd0;
        end
        if (tail_cnt >= TailLen) begin
          login_hit = 1'b1;
        end
      end
    end
    if (!quote_seen) begin
      if (b == QuoteCode) begin
        quote_seen = 1'b1;
        sig_idx = 5'd1;
      end
    end else if (sig_idx < SigLen) begin
      if (b != HostSig[8*(SigBytes - 1 - sig_idx) +: 8]) begin
        sig_bad = 1'b1;
      end
      sig_idx = sig_idx + 5'd1;
      if (sig_idx >= SigLen && !sig_bad) begin
        control_hit = 1'b1;
      end
    end
    has_res = it.end_of_payload;
    res.login_match = login_hit;
    res.control_match = control_hit;
    if (has_res) begin
      clear_tracking();
    end
  endtask

  task automatic put_byte(input logic [7:0] b);
    payload_text.push_back(b);
  endtask

  task automatic put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      put_byte(s[i]);
    end
  endtask

  task automatic put_tail_bytes(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      put_byte(TailText[8*(4 - i) +: 8]);
    end
  endtask

  task automatic put_host_sig(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      put_byte(HostSig[8*(SigBytes - 1 - i) +: 8]);
    end
  endtask

  // Moves the payload under construction into the request queue.
  task automatic ship_payload(input bit pause, input bit hold);
    queued_byte_t qb;
    int i;
    for (i = 0; i < payload_text.size(); i++) begin
      qb.item.data_byte = payload_text[i];
      qb.item.end_of_payload = (i == payload_text.size() - 1);
      qb.pause = pause && (i == 0);
      qb.hold = hold && (i == 0);
      byte_queue.push_back(qb);
    end
    built_bytes += payload_text.size();
    built_payloads++;
    payload_text.delete();
  endtask

  function automatic string login_start(input int alt);
    case (alt)
      0: return "VER ";
      1: return "CVR";
      2: return "USR";
      default: return "ANS";
    endcase
  endfunction

  task automatic build_random_payload();
    int kind;
    int alt;
    int idx;
    string s;
    logic [7:0] b;
    kind = $urandom_range(0, 9);
    if (kind <= 2) begin
      alt = $urandom_range(0, 3);
      s = login_start(alt);
      if ($urandom_range(0, 4) == 0) begin
        s = s.substr(0, $urandom_range(0, s.len() - 2));
      end
      put_text(s);
      if (alt == VerAlt) begin
        // Filler drawn partly from the tail's own letters to exercise restarts.
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 1) == 1) begin
            put_byte(TailText[8*$urandom_range(0, 4) +: 8]);
          end else begin
            put_byte(8'($urandom_range(0, 255)));
          end
        end
        put_tail_bytes(($urandom_range(0, 1) == 1) ? 5 : $urandom_range(0, 4));
      end else begin
        repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(0, 255)));
      end
    end else if (kind <= 5) begin
      repeat ($urandom_range(0, 4)) begin
        b = 8'($urandom_range(0, 255));
        if (b == QuoteCode) begin
          b = 8'h21;
        end
        put_byte(b);
      end
      put_host_sig(($urandom_range(0, 2) == 0) ? $urandom_range(1, SigBytes - 1) : SigBytes);
      repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
    end else if (kind == 6) begin
      put_text(login_start($urandom_range(1, 3)));
      put_host_sig(SigBytes);
    end else begin
      repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 3) == 0) begin
      idx = $urandom_range(0, payload_text.size() - 1);
      payload_text[idx] = payload_text[idx] ^ 8'($urandom_range(1, 255));
    end
    if ($urandom_range(0, 7) == 0) begin
      idx = $urandom_range(0, payload_text.size() - 1);
      payload_text[idx] = NulCode;
    end
  endtask

  // Request driver: presents queued bytes at the falling edge.
  always @(negedge clk) begin : driver
    queued_byte_t cur;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // Request still waiting for acceptance; hold it.
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (byte_queue.size() == 0) begin
      in_valid <= 1'b0;
    end else if (byte_queue[0].pause && expected_results.size() != 0) begin
      in_valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      gap_left = $urandom_range(0, 9);
      in_valid <= 1'b0;
    end else begin
      cur = byte_queue.pop_front();
      cur_hold = cur.hold;
      in_item <= cur.item;
      in_valid <= 1'b1;
    end
  end

  // Result receiver: random short stalls plus one long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: checks results against the oldest prediction, then predicts new requests.
  always @(posedge clk) begin : monitor
    out_item_t want;
    out_item_t res;
    bit has_res;
    in_took = 1'b0;
    calm = (byte_queue.size() < CalmTail);
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: login_match=%0b control_match=%0b",
                 out_item.login_match, out_item.control_match);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_item.login_match !== want.login_match) begin
            $error("login_match: expected %0b, got %0b", want.login_match, out_item.login_match);
            errors++;
          end
          if (out_item.control_match !== want.control_match) begin
            $error("control_match: expected %0b, got %0b",
                   want.control_match, out_item.control_match);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        in_took = 1'b1;
        bytes_taken++;
        if (cur_hold) begin
          hold_req = 1'b1;
        end
        classify_byte(in_item, has_res, res);
        if (has_res) begin
          expected_results.push_back(res);
          payloads_done++;
          login_hits += res.login_match;
          control_hits += res.control_match;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("payload_signature_classifier_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int random_start;
    int payload_start;
    bit hold_done;
    bit first;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    clear_tracking();

    // Directed payloads: each opening, tail handling, NUL cut-off and window cases.
    put_text("CVR"); ship_payload(1'b0, 1'b0);
    put_text("USR!"); ship_payload(1'b0, 1'b0);
    put_text("ANS"); ship_payload(1'b0, 1'b0);
    put_text("VER "); put_tail_bytes(5); ship_payload(1'b0, 1'b0);
    // The prefix space cannot also start the tail.
    put_text("VER"); put_tail_bytes(5); ship_payload(1'b0, 1'b0);
    put_text("VER   "); put_tail_bytes(5); ship_payload(1'b0, 1'b0);
    put_text("CV"); ship_payload(1'b0, 1'b0);
    put_text("VER "); put_tail_bytes(4); ship_payload(1'b0, 1'b0);
    put_text("C"); put_byte(NulCode); put_text("VR"); ship_payload(1'b0, 1'b0);
    put_text("VER "); put_byte(NulCode); put_tail_bytes(5); ship_payload(1'b0, 1'b0);
    put_text("xCVR"); ship_payload(1'b0, 1'b0);
    put_byte(8'hFF); ship_payload(1'b0, 1'b0);
    put_byte(NulCode); ship_payload(1'b0, 1'b0);
    put_host_sig(SigBytes); ship_payload(1'b0, 1'b0);
    put_byte(NulCode); put_host_sig(SigBytes); ship_payload(1'b0, 1'b0);
    put_text("USR"); put_host_sig(SigBytes); put_byte(8'h7F); ship_payload(1'b0, 1'b0);
    put_host_sig(11); ship_payload(1'b0, 1'b0);
    put_host_sig(SigBytes); payload_text[13] = 8'h80; ship_payload(1'b0, 1'b0);
    put_byte(QuoteCode); put_host_sig(SigBytes - 1); ship_payload(1'b0, 1'b0);
    put_text("ANS"); ship_payload(1'b1, 1'b0);

    random_start = built_bytes;
    payload_start = built_payloads;
    hold_done = 1'b0;
    while (built_bytes < random_start + RandomBytes ||
           built_payloads < payload_start + MinPayloads) begin
      if (!hold_done && built_bytes >= random_start + HoldPoint) begin
        // One-byte payloads behind a long receiver hold fill the block and stall its input.
        first = 1'b1;
        repeat (HoldBurst) begin
          put_byte(8'($urandom_range(0, 255)));
          ship_payload(1'b0, first);
          first = 1'b0;
        end
        put_text("CVR");
        ship_payload(1'b1, 1'b0);
        hold_done = 1'b1;
      end
      build_random_payload();
      ship_payload($urandom_range(0, 30) == 0, 1'b0);
    end

    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (byte_queue.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d bytes in %0d payloads: login openings, tails, NUL cut-offs,",
             bytes_taken, payloads_done);
    $display("host signature windows and a long output hold; %0d login and %0d control hits.",
             login_hits, control_hits);
    if (errors == 0) begin
      $display("payload_signature_classifier_tb: done, clean");
    end else begin
      $display("payload_signature_classifier_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ payload_signature_classifier.f @@
design/psc_pkg.sv
design/psc_login.sv
design/psc_control.sv
design/payload_signature_classifier.sv
tb/payload_signature_classifier_tb.sv
